/* hdl/rbd_pkg.sv */
`default_nettype none

package rbd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int DIM_W = 13;
  localparam int CH_W = 8;
  localparam int SUM_W = CH_W + 1;
  localparam int NUM_CH = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(4096);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic {
    CMD_STORE,
    CMD_BLEND
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [DIM_W-1:0] col;
    logic [NUM_CH-1:0][SUM_W-1:0] sums;
    logic done;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/rbd_stream_if.sv */
`default_nettype none

interface rbd_in_if;
  import rbd_pkg::*;

  logic valid;
  logic ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_alpha;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface rbd_out_if;
  import rbd_pkg::*;

  logic valid;
  logic ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  logic frame_done;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_done,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_done,
                output ready);
endinterface

`default_nettype wire

/* hdl/rbd_front.sv */
`default_nettype none

module rbd_front #(
  parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
  rbd_in_if.sink                              in_pix,
  input  wire logic                           q_full,
  output logic                                q_push,
  output rbd_pkg::cmd_t                       q_cmd
);
  import rbd_pkg::*;

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [NUM_CH-1:0][CH_W-1:0] left_r, left_nxt;

  logic [NUM_CH-1:0][CH_W-1:0] pix;
  logic [DIM_W-1:0] w_eff, h_eff, w_even, h_even;
  logic [DIM_W:0] col_inc, row_inc;
  logic accept, closes_block;

  assign pix = {in_pix.in_alpha, in_pix.in_blue, in_pix.in_green, in_pix.in_red};
  assign in_pix.ready = !q_full;
  assign accept = in_pix.valid && !q_full;

  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? DIM_W'(1) : height_r;
    w_even = {w_eff[DIM_W-1:1], 1'b0};
    h_even = {h_eff[DIM_W-1:1], 1'b0};
    closes_block = col_r[0] && (col_r < w_even) && (row_r < h_even);
  end

  always_comb begin
    q_cmd.kind = row_r[0] ? CMD_BLEND : CMD_STORE;
    q_cmd.col = {1'b0, col_r[DIM_W-1:1]};
    for (int i = 0; i < NUM_CH; i++) begin
      q_cmd.sums[i] = {1'b0, left_r[i]} + {1'b0, pix[i]};
    end
    q_cmd.done = (col_r[DIM_W-1:1] == w_eff[DIM_W-1:1] - 1'b1) &&
                 (row_r[DIM_W-1:1] == h_eff[DIM_W-1:1] - 1'b1);
    q_push = accept && closes_block;
  end

  always_comb begin
    width_nxt = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH: width_nxt = cfg_data;
        REG_IMAGE_HEIGHT: height_nxt = cfg_data;
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    left_nxt = left_r;
    col_inc = {1'b0, col_r} + 1'b1;
    row_inc = {1'b0, row_r} + 1'b1;
    if (accept) begin
      if (!col_r[0]) begin
        left_nxt = pix;
      end
      if (col_inc >= {1'b0, w_eff}) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= DIM_RESET;
      height_r <= DIM_RESET;
      col_r <= '0;
      row_r <= '0;
      left_r <= '0;
    end else begin
      width_r <= width_nxt;
      height_r <= height_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/rbd_cmd_fifo.sv */
`default_nettype none

module rbd_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rbd_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output rbd_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);
  import rbd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign empty = (count_r == '0);
  assign full = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/rbd_back.sv */
`default_nettype none

module rbd_back #(
  parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire rbd_pkg::cmd_t q_head,
  output logic               q_pop,
  rbd_out_if.source          out_pix
);
  import rbd_pkg::*;

  localparam int DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [NUM_CH*SUM_W-1:0] store [DEPTH];
  logic [NUM_CH-1:0][SUM_W-1:0] top_r;
  logic [NUM_CH-1:0][SUM_W-1:0] pair_r;
  logic done_r;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [NUM_CH-1:0][CH_W-1:0] mean_r, mean_nxt;
  logic out_done_r;

  logic [AW-1:0] addr;
  logic out_adv, s1_adv, pop_store, pop_blend;

  assign addr = q_head.col[AW-1:0];
  assign out_adv = !out_valid_r || out_pix.ready;
  assign s1_adv = !s1_valid_r || out_adv;
  assign pop_store = !q_empty && (q_head.kind == CMD_STORE);
  assign pop_blend = !q_empty && (q_head.kind == CMD_BLEND) && s1_adv;
  assign q_pop = pop_store || pop_blend;

  always_ff @(posedge clk) begin
    if (pop_store) begin
      store[addr] <= q_head.sums;
    end
    if (pop_blend) begin
      top_r <= store[addr];
      pair_r <= q_head.sums;
      done_r <= q_head.done;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      mean_nxt[i] = 8'((({1'b0, top_r[i]} + {1'b0, pair_r[i]}) >> 2));
    end
    s1_valid_nxt = s1_adv ? pop_blend : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      mean_r <= mean_nxt;
      out_done_r <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_pix.valid = out_valid_r;
  assign out_pix.out_red = mean_r[0];
  assign out_pix.out_green = mean_r[1];
  assign out_pix.out_blue = mean_r[2];
  assign out_pix.out_alpha = mean_r[3];
  assign out_pix.frame_done = out_done_r;

endmodule

`default_nettype wire

/* hdl/rgba_box_downsample_2x2_core.sv */
`default_nettype none

// A block's closing pixel passes through the queue, the line store read register and the output
// register before it is offered, and is held back while the output stalls. Throughput: one pixel
// per cycle while the queue has room, set by the line store taking one write or one read a cycle.
// Reset clears the counters, the queue and the pipeline and sets the size to 4096 x 4096.
// The line store is not cleared; every entry is written on an even row before it is read.
module rgba_box_downsample_2x2_core #(
  parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
  rbd_in_if.sink                              in_pix,
  rbd_out_if.source                           out_pix
);
  import rbd_pkg::*;

  cmd_t push_cmd, head;
  logic push, pop, empty, full;

  rbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_pix   (in_pix),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  rbd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  rbd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (empty),
    .q_head  (head),
    .q_pop   (pop),
    .out_pix (out_pix)
  );

endmodule

`default_nettype wire

/* hdl/rbd_checker.sv */
`default_nettype none

module rbd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // An output beat that is offered stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat withdrawn before it was taken");

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat offered right after reset");

  // The queue only fills up through an accepted input beat.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input ready dropped without an accepted beat");

endmodule

bind rgba_box_downsample_2x2_core rbd_checker u_rbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready)
);

`default_nettype wire

/* tb/rbd_downsample_checker.sv */
`timescale 1ns / 1ps

module rbd_downsample_checker #(
  parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
  rbd_in_if                              in_pix,
  rbd_out_if                             out_pix,
  output int                             mismatches,
  output int                             pending
);
  import rbd_pkg::*;

  localparam int PAIR_SLOTS = MAX_WIDTH / 2;

  typedef logic [NUM_CH-1:0][CH_W-1:0] rgba_t;
  typedef logic [SUM_W-1:0] chan_sum_t;
  typedef logic [SUM_W:0] quad_sum_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] pair_sum_t;

  typedef struct packed {
    rgba_t color;
    logic last;
  } half_pixel_t;

  pair_sum_t top_row_sums [PAIR_SLOTS];
  rgba_t held_left;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [DIM_W-1:0] col_pos;
  logic [DIM_W-1:0] row_pos;
  half_pixel_t predicted_pixels [$];

  always @(posedge clk) begin
    int w, h, x, y, slot;
    rgba_t px;
    pair_sum_t pair, top;
    quad_sum_t total;
    half_pixel_t got, want, res;
    logic bad;
    if (!rst_n) begin
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      col_pos = '0;
      row_pos = '0;
      held_left = '0;
      predicted_pixels.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_IMAGE_WIDTH: width_reg = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end

      if (out_pix.valid && out_pix.ready) begin
        got.color = {out_pix.out_alpha, out_pix.out_blue, out_pix.out_green, out_pix.out_red};
        got.last = out_pix.frame_done;
        if (predicted_pixels.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d done=%0d", $time,
                     got.color[0], got.color[1], got.color[2], got.color[3], got.last);
          mismatches++;
        end else begin
          want = predicted_pixels.pop_front();
          bad = (got.last !== want.last);
          for (int c = 0; c < NUM_CH; c++)
            if (got.color[c] !== want.color[c]) bad = 1'b1;
          if (bad) begin
            if (mismatches < 10)
              $display("%0t: mismatch, expected r=%0d g=%0d b=%0d a=%0d done=%0d,",
                       $time, want.color[0], want.color[1], want.color[2], want.color[3],
                       want.last, " got r=%0d g=%0d b=%0d a=%0d done=%0d",
                       got.color[0], got.color[1], got.color[2], got.color[3],
                       got.last);
            mismatches++;
          end
        end
      end

      if (in_pix.valid && in_pix.ready) begin
        px = {in_pix.in_alpha, in_pix.in_blue, in_pix.in_green, in_pix.in_red};
        // A size of zero behaves as one, and the width is clamped to the line store.
        w = (width_reg == 0) ? 1 : int'(width_reg);
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = (height_reg == 0) ? 1 : int'(height_reg);
        x = col_pos;
        y = row_pos;
        slot = (x >> 1) % PAIR_SLOTS;
        if (x % 2 == 0) begin
          held_left = px;
        end else if (x < (w & ~1) && y < (h & ~1)) begin
          for (int c = 0; c < NUM_CH; c++)
            pair[c] = chan_sum_t'(held_left[c]) + chan_sum_t'(px[c]);
          if (y % 2 == 0) begin
            top_row_sums[slot] = pair;
          end else begin
            top = top_row_sums[slot];
            for (int c = 0; c < NUM_CH; c++) begin
              total = quad_sum_t'(top[c]) + quad_sum_t'(pair[c]);
              res.color[c] = total[SUM_W:2];
            end
            res.last = ((x >> 1) == (w >> 1) - 1) && ((y >> 1) == (h >> 1) - 1);
            predicted_pixels.push_back(res);
          end
        end
        if (x + 1 >= w) begin
          col_pos = '0;
          row_pos = (y + 1 >= h) ? '0 : DIM_W'(y + 1);
        end else begin
          col_pos = DIM_W'(x + 1);
        end
      end
    end
    pending <= predicted_pixels.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rbd_pkg::*;

  typedef logic [NUM_CH-1:0][CH_W-1:0] rgba_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int in_gap_max;
  int out_gap_max;
  int mismatches;
  int pending;

  rbd_in_if in_pix ();
  rbd_out_if out_pix ();

  rgba_box_downsample_2x2_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_pix   (in_pix),
    .out_pix  (out_pix)
  );

  rbd_downsample_checker downsample_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_pix     (in_pix),
    .out_pix    (out_pix),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic int gap_limit();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 14;
    endcase
  endfunction

  task automatic push_pixel(input rgba_t px);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.in_red <= px[0];
    in_pix.in_green <= px[1];
    in_pix.in_blue <= px[2];
    in_pix.in_alpha <= px[3];
    do @(posedge clk); while (!in_pix.ready);
  endtask

  task automatic push_random_pixels(input int count);
    for (int i = 0; i < count; i++)
      push_pixel({rand_channel(), rand_channel(), rand_channel(), rand_channel()});
  endtask

  task automatic resize(input int w, input int h);
    cfg_we <= 1'b1;
    cfg_idx <= REG_IMAGE_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_idx <= REG_IMAGE_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int gap;
    out_pix.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_pix.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pix.ready <= 1'b1;
      do @(posedge clk); while (!(out_pix.valid && out_pix.ready));
    end
  end

  initial begin
    int w, h, frames, per_frame, total;
    cfg_we <= 1'b0;
    cfg_idx <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    in_pix.valid <= 1'b0;
    in_pix.in_red <= '0;
    in_pix.in_green <= '0;
    in_pix.in_blue <= '0;
    in_pix.in_alpha <= '0;
    rst_n <= 1'b0;
    in_gap_max = 14;
    out_gap_max = 14;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    resize(2, 2);
    repeat (4) push_pixel('1);
    repeat (4) push_pixel('0);
    settle();

    // Zero sizes behave as one, so neither frame can complete a block.
    resize(0, 2);
    push_random_pixels(2);
    settle();
    resize(3, 0);
    push_random_pixels(3);
    settle();

    // Shrink the width in the middle of the second row; the column wraps.
    resize(4, 2);
    push_random_pixels(6);
    settle();
    resize(2, 2);
    push_random_pixels(1);
    settle();

    // Oversized height, then shrink it mid-frame so the row counter wraps.
    resize(2, 8191);
    push_random_pixels(4);
    settle();
    resize(2, 2);
    push_random_pixels(2);
    settle();

    total = 0;
    while (total < 500) begin
      case ($urandom_range(0, 7))
        0: w = $urandom_range(0, 3);
        1: w = $urandom_range(13, 40);
        default: w = $urandom_range(2, 12);
      endcase
      h = $urandom_range(0, 9);
      per_frame = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      frames = (per_frame > 120) ? 1 : $urandom_range(1, 3);
      in_gap_max = gap_limit();
      out_gap_max = gap_limit();
      resize(w, h);
      push_random_pixels(per_frame * frames);
      settle();
      total += per_frame * frames;
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/rbd_pkg.sv
hdl/rbd_stream_if.sv
hdl/rbd_front.sv
hdl/rbd_cmd_fifo.sv
hdl/rbd_back.sv
hdl/rgba_box_downsample_2x2_core.sv
hdl/rbd_checker.sv
tb/rbd_downsample_checker.sv
tb/testbench.sv
